FILE: rtl/ssnr_pkg.sv
// Shared types, constants and helpers of the seven-segment rectangle renderer.
// No dependencies.
package ssnr_pkg;

	localparam logic [15:0] INT_LIMIT   = 16'd9999;
	localparam logic [6:0]  DIGIT_PITCH = 7'd22;
	localparam logic [2:0]  LAST_CELL   = 3'd4;
	localparam logic [3:0]  CONV_STEPS  = 4'd15;

	// Signed coordinate wide enough for every unclipped corner and extent
	typedef logic signed [12:0] coord_t;

	typedef enum logic [1:0] {
		KIND_BOX   = 2'd0,
		KIND_DIGIT = 2'd1,
		KIND_DOT   = 2'd2
	} cell_kind_t;

	typedef struct packed {
		logic [8:0] x;
		logic [7:0] y;
		logic [8:0] w;
		logic [7:0] h;
	} rect_t;

	typedef struct packed {
		logic       load;
		logic       conv_step;
		logic       walk;
		logic       flush;
		logic [2:0] slot;
		logic [2:0] sub;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cell_en;
		logic sub_end;
		logic hold;
		logic flush_done;
	} dp_stat_t;

	// Segments a..g, a in bit 6
	function automatic logic [6:0] seg_of(input logic [3:0] d);
		logic [6:0] m;
		case (d)
			4'd0: m = 7'b1111110;
			4'd1: m = 7'b0110000;
			4'd2: m = 7'b1101101;
			4'd3: m = 7'b1111001;
			4'd4: m = 7'b0110011;
			4'd5: m = 7'b1011011;
			4'd6: m = 7'b1011111;
			4'd7: m = 7'b1110000;
			4'd8: m = 7'b1111111;
			4'd9: m = 7'b1111011;
			default: m = 7'b0000000;
		endcase
		return m;
	endfunction

	// Scale times a small constant
	function automatic logic [9:0] smul(input logic [2:0] s, input logic [6:0] k);
		return 10'({7'd0, s} * {3'd0, k});
	endfunction

endpackage

FILE: rtl/ssnr_clip.sv
// Clips one candidate rectangle to the screen and flags whether anything is left.
// Depends on ssnr_pkg.
module ssnr_clip #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  ssnr_pkg::coord_t cx,
	input  ssnr_pkg::coord_t cy,
	input  ssnr_pkg::coord_t cw,
	input  ssnr_pkg::coord_t ch,
	output ssnr_pkg::rect_t  rect,
	output logic             vis
);

	localparam ssnr_pkg::coord_t SW_C = ssnr_pkg::coord_t'(SCREEN_WIDTH);
	localparam ssnr_pkg::coord_t SH_C = ssnr_pkg::coord_t'(SCREEN_HEIGHT);

	ssnr_pkg::coord_t w0, h0, wl, hl, wc, hc;
	logic off;

	always_comb begin
		off = (cx < 0) || (cy < 0) || (cx >= SW_C) || (cy >= SH_C);
		w0  = (cw < 0) ? '0 : cw;
		h0  = (ch < 0) ? '0 : ch;
		wl  = SW_C - cx;
		hl  = SH_C - cy;
		wc  = (w0 > wl) ? wl : w0;
		hc  = (h0 > hl) ? hl : h0;
		vis = !off && (wc != 0) && (hc != 0);
		rect.x = cx[8:0];
		rect.y = cy[7:0];
		rect.w = wc[8:0];
		rect.h = hc[7:0];
	end

endmodule

FILE: rtl/ssnr_ctrl.sv
// Sequencer: request capture, BCD conversion count, walk over cells and rectangles, final release.
// Depends on ssnr_pkg.
module ssnr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  ssnr_pkg::dp_stat_t   stat,
	output ssnr_pkg::ctrl_cmd_t  cmd,
	output logic                 idle
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CONV  = 4'b0010,
		ST_WALK  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic [2:0] cell_q, cell_d;
	logic [2:0] sub_q, sub_d;
	logic       next_cell;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cell_d    = cell_q;
		sub_d     = sub_q;
		next_cell = 1'b0;
		cmd       = '0;
		cmd.slot  = cell_q;
		cmd.sub   = sub_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				cnt_d         = cnt_q + 4'd1;
				if (cnt_q == ssnr_pkg::CONV_STEPS) begin
					cell_d  = '0;
					sub_d   = '0;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (!stat.cell_en) begin
					next_cell = 1'b1;
				end else if (!stat.hold) begin
					if (stat.sub_end) begin
						next_cell = 1'b1;
					end else begin
						sub_d = sub_q + 3'd1;
					end
				end
				if (next_cell) begin
					sub_d = '0;
					if (cell_q == ssnr_pkg::LAST_CELL) begin
						state_d = ST_FLUSH;
					end else begin
						cell_d = cell_q + 3'd1;
					end
				end
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				if (stat.flush_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign idle = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			cell_q  <= '0;
			sub_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			cell_q  <= cell_d;
			sub_q   <= sub_d;
		end
	end

endmodule

FILE: rtl/ssnr_dp.sv
// Datapath: request registers, binary-to-BCD shifter, rectangle geometry,
// one-deep lookahead and the output register. Depends on ssnr_pkg, ssnr_clip.
module ssnr_dp #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ssnr_pkg::ctrl_cmd_t cmd,
	output ssnr_pkg::dp_stat_t  stat,
	input  logic                mode,
	input  logic [8:0]          pos_x,
	input  logic [8:0]          pos_y,
	input  logic [2:0]          scale,
	input  logic signed [15:0]  value,
	input  logic [15:0]         fg_color,
	input  logic [15:0]         bg_color,
	output logic                out_valid,
	input  logic                out_stall,
	output ssnr_pkg::rect_t     out_rect,
	output logic [15:0]         out_color,
	output logic                out_last
);

	// request registers
	logic        mode_q;
	logic [8:0]  x_q, y_q;
	logic [2:0]  s_q;
	logic [15:0] fg_q, bg_q;
	logic [15:0] bin_q;
	logic [15:0] bcd_q;

	// lookahead and output
	ssnr_pkg::rect_t pend_q, out_rect_q;
	logic [15:0]     pend_color_q, out_color_q;
	logic            pend_valid_q, out_valid_q, out_last_q;

	logic [15:0] clamped;
	logic [15:0] bcd_adj;

	ssnr_pkg::cell_kind_t kind;
	logic [3:0]  dig;
	logic [9:0]  ox, rx, ry, rw, rh;
	logic        cell_en, sub_en, sub_end;
	logic [7:0]  mask8;
	logic        d3_nz, d2_nz, d1_nz;
	ssnr_pkg::coord_t cx, cy, cw, ch;
	ssnr_pkg::rect_t  cand;
	logic        vis, cand_take, out_free, hold, load_out, flush_move;
	logic [15:0] cand_color;

	// clamp on capture
	always_comb begin
		if (value < 0) begin
			clamped = '0;
		end else if (!mode && (value > $signed(ssnr_pkg::INT_LIMIT))) begin
			clamped = ssnr_pkg::INT_LIMIT;
		end else begin
			clamped = value;
		end
	end

	// double dabble: add 3 to each digit of 5 or more, then shift
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ?
				bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			x_q    <= pos_x;
			y_q    <= pos_y;
			s_q    <= scale;
			fg_q   <= fg_color;
			bg_q   <= bg_color;
			bin_q  <= clamped;
			bcd_q  <= '0;
		end else if (cmd.conv_step) begin
			bcd_q <= {bcd_adj[14:0], bin_q[15]};
			bin_q <= {bin_q[14:0], 1'b0};
		end
	end

	assign d3_nz = (bcd_q[15:12] != 4'd0);
	assign d2_nz = (bcd_q[11:8] != 4'd0);
	assign d1_nz = (bcd_q[7:4] != 4'd0);

	// cell selection
	always_comb begin
		kind    = ssnr_pkg::KIND_DIGIT;
		dig     = bcd_q[3:0];
		ox      = '0;
		cell_en = 1'b1;
		case (cmd.slot)
			3'd0: begin
				if (!mode_q) begin
					kind = ssnr_pkg::KIND_BOX;
				end else begin
					dig     = bcd_q[15:12];
					cell_en = d3_nz;
				end
			end
			3'd1: begin
				if (!mode_q) begin
					dig     = bcd_q[15:12];
					cell_en = d3_nz;
				end else begin
					dig = bcd_q[11:8];
					ox  = ssnr_pkg::smul(s_q, ssnr_pkg::DIGIT_PITCH);
				end
			end
			3'd2: begin
				if (!mode_q) begin
					dig     = bcd_q[11:8];
					ox      = ssnr_pkg::smul(s_q, ssnr_pkg::DIGIT_PITCH);
					cell_en = d3_nz || d2_nz;
				end else begin
					dig = bcd_q[7:4];
					ox  = ssnr_pkg::smul(s_q, 7'd44);
				end
			end
			3'd3: begin
				if (!mode_q) begin
					dig     = bcd_q[7:4];
					ox      = ssnr_pkg::smul(s_q, 7'd44);
					cell_en = d3_nz || d2_nz || d1_nz;
				end else begin
					kind = ssnr_pkg::KIND_DOT;
					ox   = ssnr_pkg::smul(s_q, 7'd66);
				end
			end
			3'd4: begin
				dig = bcd_q[3:0];
				ox  = ssnr_pkg::smul(s_q, 7'd66);
			end
			default: begin
				cell_en = 1'b0;
			end
		endcase
	end

	// rectangle within the cell
	always_comb begin
		rx      = '0;
		ry      = '0;
		rw      = '0;
		rh      = '0;
		mask8   = {1'b1, ssnr_pkg::seg_of(dig)};
		sub_en  = 1'b1;
		sub_end = 1'b1;
		case (kind)
			ssnr_pkg::KIND_BOX: begin
				rw = ssnr_pkg::smul(s_q, 7'd88);
				rh = ssnr_pkg::smul(s_q, 7'd32);
			end
			ssnr_pkg::KIND_DOT: begin
				sub_end = (cmd.sub == 3'd1);
				if (cmd.sub == 3'd0) begin
					rw = ssnr_pkg::smul(s_q, 7'd6);
					rh = ssnr_pkg::smul(s_q, 7'd32);
				end else begin
					ry = ssnr_pkg::smul(s_q, 7'd26);
					rw = ssnr_pkg::smul(s_q, 7'd4);
					rh = ssnr_pkg::smul(s_q, 7'd4);
				end
			end
			ssnr_pkg::KIND_DIGIT: begin
				sub_end = (cmd.sub == 3'd7);
				sub_en  = mask8[3'd7 - cmd.sub];
				case (cmd.sub)
					3'd0: begin // cell background
						rw = ssnr_pkg::smul(s_q, 7'd18);
						rh = ssnr_pkg::smul(s_q, 7'd32);
					end
					3'd1: begin // a
						rx = ssnr_pkg::smul(s_q, 7'd4);
						rw = ssnr_pkg::smul(s_q, 7'd10);
						rh = ssnr_pkg::smul(s_q, 7'd4);
					end
					3'd2: begin // b
						rx = ssnr_pkg::smul(s_q, 7'd14);
						ry = ssnr_pkg::smul(s_q, 7'd4);
						rw = ssnr_pkg::smul(s_q, 7'd4);
						rh = ssnr_pkg::smul(s_q, 7'd10);
					end
					3'd3: begin // c
						rx = ssnr_pkg::smul(s_q, 7'd14);
						ry = ssnr_pkg::smul(s_q, 7'd18);
						rw = ssnr_pkg::smul(s_q, 7'd4);
						rh = ssnr_pkg::smul(s_q, 7'd10);
					end
					3'd4: begin // d
						rx = ssnr_pkg::smul(s_q, 7'd4);
						ry = ssnr_pkg::smul(s_q, 7'd28);
						rw = ssnr_pkg::smul(s_q, 7'd10);
						rh = ssnr_pkg::smul(s_q, 7'd4);
					end
					3'd5: begin // e
						ry = ssnr_pkg::smul(s_q, 7'd18);
						rw = ssnr_pkg::smul(s_q, 7'd4);
						rh = ssnr_pkg::smul(s_q, 7'd10);
					end
					3'd6: begin // f
						ry = ssnr_pkg::smul(s_q, 7'd4);
						rw = ssnr_pkg::smul(s_q, 7'd4);
						rh = ssnr_pkg::smul(s_q, 7'd10);
					end
					3'd7: begin // g
						rx = ssnr_pkg::smul(s_q, 7'd4);
						ry = ssnr_pkg::smul(s_q, 7'd14);
						rw = ssnr_pkg::smul(s_q, 7'd10);
						rh = ssnr_pkg::smul(s_q, 7'd4);
					end
					default: begin
						sub_en = 1'b0;
					end
				endcase
			end
			default: begin
				sub_en = 1'b0;
			end
		endcase
	end

	// absolute corner; the dot cell sits six columns left of its pitch slot
	always_comb begin
		cx = ssnr_pkg::coord_t'({4'd0, x_q}) + ssnr_pkg::coord_t'({3'd0, ox})
			+ ssnr_pkg::coord_t'({3'd0, rx});
		if (kind == ssnr_pkg::KIND_DOT) begin
			cx = cx - ssnr_pkg::coord_t'(6);
		end
		cy = ssnr_pkg::coord_t'({4'd0, y_q}) + ssnr_pkg::coord_t'({3'd0, ry});
		cw = ssnr_pkg::coord_t'({3'd0, rw});
		ch = ssnr_pkg::coord_t'({3'd0, rh});
	end

	assign cand_color = (cmd.sub == 3'd0) ? bg_q : fg_q;

	ssnr_clip #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_clip (
		.cx  (cx),
		.cy  (cy),
		.cw  (cw),
		.ch  (ch),
		.rect(cand),
		.vis (vis)
	);

	// a visible rectangle pushes the held one out, so last is known at the end
	assign out_free   = !out_valid_q || !out_stall;
	assign hold       = cmd.walk && cell_en && sub_en && vis && pend_valid_q && !out_free;
	assign cand_take  = cmd.walk && cell_en && sub_en && vis && !hold;
	assign flush_move = cmd.flush && pend_valid_q && out_free;
	assign load_out   = (cand_take && pend_valid_q) || flush_move;

	always_ff @(posedge clk) begin
		if (cand_take) begin
			pend_q       <= cand;
			pend_color_q <= cand_color;
		end
		if (load_out) begin
			out_rect_q  <= pend_q;
			out_color_q <= pend_color_q;
			out_last_q  <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cand_take) begin
				pend_valid_q <= 1'b1;
			end else if (flush_move) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.cell_en    = cell_en;
	assign stat.sub_end    = sub_end;
	assign stat.hold       = hold;
	assign stat.flush_done = !pend_valid_q || out_free;

	assign out_valid = out_valid_q;
	assign out_rect  = out_rect_q;
	assign out_color = out_color_q;
	assign out_last  = out_last_q;

endmodule

FILE: rtl/seven_segment_number_rect_renderer_core.sv
// Seven-segment number renderer: top level joining sequencer and datapath.
// Depends on ssnr_pkg, ssnr_ctrl, ssnr_dp (and ssnr_clip below it).
//
// One request (mode, position, scale, value, colours) is turned into the
// ordered run of filled rectangles that paint the number as scaled
// seven-segment digits, each clipped to a SCREEN_WIDTH x SCREEN_HEIGHT
// screen; rectangles that end up empty are dropped and the final one sent
// carries last. A request that paints nothing yields no rectangle at all.
// Sequence: the request is taken, then a binary-to-BCD shifter runs over
// all 16 bits, one bit per cycle. The walk then visits every cell: a cell
// that is blanked is a single step, the integer background box one, the
// decimal dot two and a drawn digit eight steps (cell background plus
// segments a..g), after which the held final rectangle is released.
// in_stall is low only while the sequencer is idle. While out_stall holds
// a full output register, the walk waits at each visible rectangle that
// would push a held one out, and the release of the final one waits too.
// Rectangles leave through a one-deep lookahead register and an output
// register, so the next request can start while the last rectangle of the
// previous one still waits to be taken.
module seven_segment_number_rect_renderer_core #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic               clk,
	input  logic               arst_n,

	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [8:0]         pos_x,
	input  logic [8:0]         pos_y,
	input  logic [2:0]         scale,
	input  logic signed [15:0] value,
	input  logic [15:0]        fg_color,
	input  logic [15:0]        bg_color,

	// rectangle channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [8:0]         rect_x,
	output logic [7:0]         rect_y,
	output logic [8:0]         rect_w,
	output logic [7:0]         rect_h,
	output logic [15:0]        fill_color,
	output logic               last
);

	ssnr_pkg::ctrl_cmd_t cmd;
	ssnr_pkg::dp_stat_t  stat;
	ssnr_pkg::rect_t     rect;
	logic                idle;

	// sequencer: capture, conversion count, cell/segment walk, final release
	ssnr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.stat    (stat),
		.cmd     (cmd),
		.idle    (idle)
	);

	// a new request is only taken between requests
	assign in_stall = !idle;

	// datapath: geometry, clipping, lookahead and output register
	ssnr_dp #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.mode     (mode),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.scale    (scale),
		.value    (value),
		.fg_color (fg_color),
		.bg_color (bg_color),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_rect (rect),
		.out_color(fill_color),
		.out_last (last)
	);

	assign rect_x = rect.x;
	assign rect_y = rect.y;
	assign rect_w = rect.w;
	assign rect_h = rect.h;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for seven_segment_number_rect_renderer_core: directed table, then random requests.
// Every rectangle is checked against an in-bench painter of the number; needs only the core RTL.
module tb;

	localparam int SCR_W            = 320;
	localparam int SCR_H            = 240;
	localparam logic MODE_INT       = 1'b0;
	localparam logic MODE_TENTHS    = 1'b1;
	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int DRAIN_CYCLES     = 60;
	localparam int HOLD_CYCLES      = 400;
	localparam int RANDOM_PER_PHASE = 150;
	localparam logic [15:0] FG_DEF  = 16'h07E0;
	localparam logic [15:0] BG_DEF  = 16'h001F;

	// How a directed row is checked: by the painter, nothing at all, or one typed rectangle
	typedef enum logic [1:0] {
		CHK_PREDICT = 2'd0,
		CHK_NONE    = 2'd1,
		CHK_ONE     = 2'd2
	} row_check_t;

	typedef struct packed {
		logic        mode;
		logic [8:0]  x;
		logic [8:0]  y;
		logic [2:0]  scale;
		logic [15:0] value;
		logic [15:0] fg;
		logic [15:0] bg;
	} number_req_t;

	typedef struct packed {
		logic [8:0]  x;
		logic [7:0]  y;
		logic [8:0]  w;
		logic [7:0]  h;
		logic [15:0] color;
		logic        last;
	} rect_exp_t;

	typedef struct packed {
		number_req_t req;
		row_check_t  chk;
		rect_exp_t   rect;
	} dir_row_t;

	localparam rect_exp_t NO_RECT = '0;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic               mode       = 1'b0;
	logic [8:0]         pos_x      = '0;
	logic [8:0]         pos_y      = '0;
	logic [2:0]         scale      = 3'd1;
	logic signed [15:0] value      = '0;
	logic [15:0]        fg_color   = '0;
	logic [15:0]        bg_color   = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [8:0]         rect_x;
	logic [7:0]         rect_y;
	logic [8:0]         rect_w;
	logic [7:0]         rect_h;
	logic [15:0]        fill_color;
	logic               last;

	rect_exp_t   pending_rects[$];	// rectangles still owed by the core, oldest first
	rect_exp_t   painted[$];		// scratch list for the request being painted
	dir_row_t    dir_rows[$];
	int          fail_count    = 0;
	int          cycle_count   = 0;
	int          tx_idle_pct   = 0;
	int          rx_idle_pct   = 0;
	int          hold_requests = 0;
	int          hold_served   = 0;
	int          hold_left     = 0;

	seven_segment_number_rect_renderer_core #(
		.SCREEN_WIDTH (SCR_W),
		.SCREEN_HEIGHT(SCR_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.scale     (scale),
		.value     (value),
		.fg_color  (fg_color),
		.bg_color  (bg_color),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rect_x    (rect_x),
		.rect_y    (rect_y),
		.rect_w    (rect_w),
		.rect_h    (rect_h),
		.fill_color(fill_color),
		.last      (last)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------- painter

	// Segments a..g, a in bit 6
	function automatic logic [6:0] lit_segments(input int d);
		logic [6:0] m;
		case (d)
			0: m = 7'b1111110;
			1: m = 7'b0110000;
			2: m = 7'b1101101;
			3: m = 7'b1111001;
			4: m = 7'b0110011;
			5: m = 7'b1011011;
			6: m = 7'b1011111;
			7: m = 7'b1110000;
			8: m = 7'b1111111;
			default: m = 7'b1111011;
		endcase
		return m;
	endfunction

	// Clip to the screen; a corner off the screen or an empty box paints nothing
	function automatic void clip_rect(input int x, input int y, input int w, input int h,
			input logic [15:0] c);
		rect_exp_t r;
		if (x < 0 || y < 0 || x >= SCR_W || y >= SCR_H)
			return;
		if (w < 0)
			w = 0;
		if (h < 0)
			h = 0;
		if (x + w > SCR_W)
			w = SCR_W - x;
		if (y + h > SCR_H)
			h = SCR_H - y;
		if (w == 0 || h == 0)
			return;
		r.x     = 9'(x);
		r.y     = 8'(y);
		r.w     = 9'(w);
		r.h     = 8'(h);
		r.color = c;
		r.last  = 1'b0;
		painted.push_back(r);
	endfunction

	// Cell background, then lit segments in a..g order
	function automatic void paint_digit(input int x, input int y, input int s, input int d,
			input logic [15:0] fg, input logic [15:0] bg);
		int w;
		int h;
		int t;
		int v;
		logic [6:0] m;
		w = 18 * s;
		h = 32 * s;
		t = 4 * s;
		v = (h - 3 * t) / 2;
		m = lit_segments(d % 10);
		clip_rect(x, y, w, h, bg);
		if (m[6]) clip_rect(x + t, y, w - 2 * t, t, fg);
		if (m[5]) clip_rect(x + w - t, y + t, t, v, fg);
		if (m[4]) clip_rect(x + w - t, y + 2 * t + v, t, v, fg);
		if (m[3]) clip_rect(x + t, y + h - t, w - 2 * t, t, fg);
		if (m[2]) clip_rect(x, y + 2 * t + v, t, v, fg);
		if (m[1]) clip_rect(x, y + t, t, v, fg);
		if (m[0]) clip_rect(x + t, y + t + v, w - 2 * t, t, fg);
	endfunction

	// Works out every rectangle of one request and queues them behind earlier ones
	function automatic void paint_number(input number_req_t r);
		int x;
		int y;
		int s;
		int dx;
		int val;
		int dot_x;
		bit started;
		rect_exp_t e;
		painted.delete();
		x = r.x;
		y = r.y;
		s = r.scale;
		dx = 22 * s;
		val = $signed(r.value);
		if (val < 0)
			val = 0;
		if (r.mode == MODE_INT) begin
			started = 1'b0;
			if (val > 9999)
				val = 9999;
			clip_rect(x, y, 4 * dx, 32 * s, r.bg);
			if ((val / 1000) % 10 != 0) begin
				paint_digit(x, y, s, (val / 1000) % 10, r.fg, r.bg);
				started = 1'b1;
			end
			if ((val / 100) % 10 != 0 || started) begin
				paint_digit(x + dx, y, s, (val / 100) % 10, r.fg, r.bg);
				started = 1'b1;
			end
			if ((val / 10) % 10 != 0 || started)
				paint_digit(x + 2 * dx, y, s, (val / 10) % 10, r.fg, r.bg);
			paint_digit(x + 3 * dx, y, s, val % 10, r.fg, r.bg);
		end else begin
			dot_x = x + 3 * dx - 6;
			if ((val / 1000) % 10 != 0)
				paint_digit(x, y, s, (val / 1000) % 10, r.fg, r.bg);
			paint_digit(x + dx, y, s, (val / 100) % 10, r.fg, r.bg);
			paint_digit(x + 2 * dx, y, s, (val / 10) % 10, r.fg, r.bg);
			clip_rect(dot_x, y, 6 * s, 32 * s, r.bg);
			clip_rect(dot_x, y + 26 * s, 4 * s, 4 * s, r.fg);
			paint_digit(x + 3 * dx, y, s, val % 10, r.fg, r.bg);
		end
		if (painted.size() > 0) begin
			e = painted.pop_back();
			e.last = 1'b1;
			painted.push_back(e);
		end
		foreach (painted[i])
			pending_rects.push_back(painted[i]);
	endfunction

	// ---------------------------------------------------------------- request side

	task automatic add_row(input logic md, input logic [8:0] x, input logic [8:0] y,
			input logic [2:0] s, input logic [15:0] v, input logic [15:0] fg,
			input logic [15:0] bg, input row_check_t chk, input rect_exp_t r);
		dir_row_t row;
		row.req  = {md, x, y, s, v, fg, bg};
		row.chk  = chk;
		row.rect = r;
		dir_rows.push_back(row);
	endtask

	// Called just after a rising edge; returns at the edge that takes the request
	task automatic send_request(input number_req_t r, input row_check_t chk,
			input rect_exp_t one);
		in_valid <= 1'b1;
		mode     <= r.mode;
		pos_x    <= r.x;
		pos_y    <= r.y;
		scale    <= r.scale;
		value    <= r.value;
		fg_color <= r.fg;
		bg_color <= r.bg;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		case (chk)
			CHK_PREDICT: paint_number(r);
			CHK_ONE:     pending_rects.push_back(one);
			default:     ;
		endcase
	endtask

	task automatic idle_for(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_rects.size() != 0)
			@(posedge clk);
	endtask

	// Random gap after an accepted request, per the current sender idling rate
	task automatic sender_gap();
		if ($urandom_range(99) < tx_idle_pct)
			idle_for($urandom_range(8, 1));
	endtask

	function automatic number_req_t rand_req();
		number_req_t r;
		r.mode  = 1'($urandom_range(1));
		r.scale = ($urandom_range(19) == 0) ? 3'd0 : 3'($urandom_range(7, 1));
		if ($urandom_range(4) != 0) begin
			r.x = 9'($urandom_range(SCR_W - 1));
			r.y = 9'($urandom_range(SCR_H - 1));
		end else begin
			r.x = 9'($urandom);
			r.y = 9'($urandom);
		end
		case ($urandom_range(3))
			0:       r.value = 16'($urandom);
			1:       r.value = 16'($urandom_range(9999));
			2:       r.value = 16'($urandom_range(999));
			default: r.value = 16'($urandom_range(99));
		endcase
		r.fg = 16'($urandom);
		r.bg = 16'($urandom);
		return r;
	endfunction

	// ---------------------------------------------------------------- rectangle side

	// Per-cycle stall; a hold-off request from the stimulus forces a long stall stretch
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_left   <= HOLD_CYCLES;
			out_stall   <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			fail_count++;
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		rect_exp_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rects.size() == 0) begin
				fail_count++;
				$display("%0t: rect expected none actual x=%0d y=%0d w=%0d h=%0d", $time,
					rect_x, rect_y, rect_w, rect_h);
			end else begin
				e = pending_rects.pop_front();
				check_field("rect_x", e.x, rect_x);
				check_field("rect_y", e.y, rect_y);
				check_field("rect_w", e.w, rect_w);
				check_field("rect_h", e.h, rect_h);
				check_field("fill_color", e.color, fill_color);
				check_field("last", e.last, last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("seven_segment_number_rect_renderer_core: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		// Directed table: clamps, blanking, every digit, both modes, colour extremes,
		// overhang, off-screen corners and zero scale
		add_row(MODE_INT,    9'd0,   9'd0,   3'd1, 16'd0,     FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_INT,    9'd0,   9'd0,   3'd1, 16'd8888,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_INT,    9'd0,   9'd0,   3'd1, 16'd9999,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_INT,    9'd0,   9'd0,   3'd1, 16'd12345, FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_INT,    9'd0,   9'd0,   3'd1, 16'hFFFF,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_INT,    9'd0,   9'd0,   3'd1, 16'h8000,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_INT,    9'd0,   9'd0,   3'd1, 16'h7FFF,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_INT,    9'd10,  9'd20,  3'd2, 16'd1000,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_INT,    9'd10,  9'd20,  3'd2, 16'd1234,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_INT,    9'd10,  9'd20,  3'd2, 16'd5679,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_INT,    9'd10,  9'd20,  3'd2, 16'd7,     FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_INT,    9'd10,  9'd20,  3'd2, 16'd305,   FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_INT,    9'd0,   9'd0,   3'd7, 16'd8888,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_TENTHS, 9'd0,   9'd0,   3'd1, 16'd0,     FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_TENTHS, 9'd0,   9'd0,   3'd1, 16'd1234,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_TENTHS, 9'd0,   9'd0,   3'd1, 16'd999,   FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_TENTHS, 9'd0,   9'd0,   3'd1, 16'h7FFF,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_TENTHS, 9'd0,   9'd0,   3'd1, 16'hFFFB,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_TENTHS, 9'd300, 9'd200, 3'd2, 16'd5670,  FG_DEF, BG_DEF, CHK_PREDICT, NO_RECT);
		add_row(MODE_TENTHS, 9'd0,   9'd0,   3'd0, 16'd88,    FG_DEF, BG_DEF, CHK_NONE,    NO_RECT);
		add_row(MODE_INT,    9'd100, 9'd100, 3'd0, 16'd8888,  FG_DEF, BG_DEF, CHK_NONE,    NO_RECT);
		add_row(MODE_INT,    9'd511, 9'd511, 3'd3, 16'd8888,  FG_DEF, BG_DEF, CHK_NONE,    NO_RECT);
		// Bottom-right pixel: only the background box survives, cut to 1x1
		add_row(MODE_INT,    9'd319, 9'd239, 3'd1, 16'd0,     16'hFFFF, 16'h0000, CHK_ONE,
			{9'd319, 8'd239, 9'd1, 8'd1, 16'h0000, 1'b1});
		// Right edge: box cut to one column, digits all off-screen
		add_row(MODE_INT,    9'd319, 9'd0,   3'd1, 16'd5,     16'h0000, 16'hFFFF, CHK_ONE,
			{9'd319, 8'd0, 9'd1, 8'd32, 16'hFFFF, 1'b1});
		add_row(MODE_TENTHS, 9'd0,   9'd239, 3'd4, 16'd321,   16'hFFFF, 16'hFFFF, CHK_PREDICT,
			NO_RECT);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].rect);
			if ($urandom_range(1))
				idle_for($urandom_range(3, 1));
		end
		wait_drained();

		// Random phases: sender-light/receiver-heavy, the reverse, then flat out
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct <= (phase == 0) ? 30 : (phase == 1) ? 64 : 0;
			rx_idle_pct <= (phase == 0) ? 64 : (phase == 1) ? 30 : 0;
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				send_request(rand_req(), CHK_PREDICT, NO_RECT);
				// Long receiver hold-off while requests keep coming, to back the core up
				if (phase == 2 && k == 20)
					hold_requests <= hold_requests + 1;
				sender_gap();
			end
			// Sender pause until every owed rectangle is out
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_rects.size() == 0)
			$display("seven_segment_number_rect_renderer_core: match");
		else
			$display("seven_segment_number_rect_renderer_core: mismatch");
		$finish;
	end

endmodule
